// ===== hdl/prm_pkg.sv =====
// Shared types and constants for the probe response matcher.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package prm_pkg;

  // Table size default and fixed field widths.
  localparam int DefaultEntries = 16;
  localparam int SlotW          = 4;
  localparam int CountW         = 5;
  localparam int AddrW          = 3;

  // Protocol numbers and ICMP type that a response is checked against.
  localparam logic [7:0] IpprotoTcp    = 8'd6;
  localparam logic [7:0] IpprotoIcmp   = 8'd1;
  localparam logic [7:0] IcmpEchoReply = 8'd0;

  // Probe kinds as stored in an entry.
  localparam logic [1:0] KindTcp  = 2'd1;
  localparam logic [1:0] KindIcmp = 2'd2;

  // Request function carried on the input tuser.
  localparam logic FuncLoad     = 1'b0;
  localparam logic FuncResponse = 1'b1;

  // Saturation point of the batch match count.
  localparam logic [CountW-1:0] CountMax = CountW'(16);

  // Configuration register index (word address bit).
  localparam logic RegLocalAddress = 1'b0;

  typedef enum logic [1:0] {
    StIdle     = 2'd0,
    StPending  = 2'd1,
    StAnswered = 2'd2
  } status_e;

  // One request as it travels down the chain of cells.
  typedef struct packed {
    logic             valid;
    logic             func;
    logic [SlotW-1:0] slot;
    logic [1:0]       kind;
    logic [31:0]      remote;
    logic             dst_ok;
    logic             tcp_ok;
    logic             icmp_ok;
    logic [15:0]      first;
    logic [15:0]      second;
    logic             last;
    logic             hit;
    logic [SlotW-1:0] hit_slot;
  } req_t;

endpackage

`default_nettype wire

// ===== hdl/prm_cell.sv =====
// One table entry of the matcher with its stage of the request chain.
// Depends on prm_pkg for the request struct and codes.
`timescale 1ns / 1ps
`default_nettype none

module prm_cell
  import prm_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  advance_i,
  input  req_t req_i,
  output req_t req_o
);

  logic [1:0]  kind_q;
  status_e     status_q;
  logic [31:0] remote_q;
  logic [15:0] first_q;
  logic [15:0] second_q;
  req_t        req_q;
  req_t        req_d;

  logic        take;
  logic        load_here;
  logic        kind_ok;
  logic        entry_hit;
  logic        claim;

  assign take = advance_i && req_i.valid;

  // Slot numbers past the table never select a cell.
  assign load_here = take && (req_i.func == FuncLoad) &&
                     (INDEX < (1 << SlotW)) && (req_i.slot == SlotW'(INDEX));

  always_comb begin
    case (kind_q)
      KindTcp:  kind_ok = req_i.tcp_ok;
      KindIcmp: kind_ok = req_i.icmp_ok;
      default:  kind_ok = 1'b0;
    endcase
  end

  assign entry_hit = (status_q == StPending) && kind_ok && req_i.dst_ok &&
                     (remote_q == req_i.remote) && (first_q == req_i.first) &&
                     (second_q == req_i.second);

  // Only the first pending match along the chain claims the response.
  assign claim = take && (req_i.func == FuncResponse) && !req_i.hit && entry_hit;

  always_comb begin
    req_d = req_i;
    if (claim) begin
      req_d.hit      = 1'b1;
      req_d.hit_slot = SlotW'(INDEX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= 2'd0;
      status_q <= StIdle;
    end else if (load_here) begin
      kind_q   <= req_i.kind;
      status_q <= StPending;
    end else if (claim) begin
      status_q <= StAnswered;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_here) begin
      remote_q <= req_i.remote;
      first_q  <= req_i.first;
      second_q <= req_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
    end else if (advance_i) begin
      req_q <= req_d;
    end
  end

  assign req_o = req_q;

endmodule

`default_nettype wire

// ===== hdl/prm_batch.sv =====
// Tail of the matcher: batch match count and the output register.
// Depends on prm_pkg for the request struct and codes.
`timescale 1ns / 1ps
`default_nettype none

module prm_batch
  import prm_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  req_t              req_i,
  input  wire               out_ready_i,
  output logic              advance_o,
  output logic              out_valid_o,
  output logic              out_matched_o,
  output logic [SlotW-1:0]  out_slot_o,
  output logic [CountW-1:0] out_count_o
);

  logic              out_valid_q;
  logic              matched_q;
  logic [SlotW-1:0]  slot_q;
  logic [CountW-1:0] shown_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_d;
  logic [CountW-1:0] shown_d;
  logic              is_resp;

  assign advance_o = !out_valid_q || out_ready_i;
  assign is_resp   = req_i.func == FuncResponse;

  always_comb begin
    shown_d = count_q;
    count_d = count_q;
    if (is_resp) begin
      if (req_i.hit && (count_q < CountMax)) begin
        shown_d = count_q + CountW'(1);
      end
      count_d = req_i.last ? '0 : shown_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else if (advance_o) begin
      out_valid_q <= req_i.valid;
      if (req_i.valid) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && req_i.valid) begin
      matched_q <= is_resp && req_i.hit;
      slot_q    <= (is_resp && req_i.hit) ? req_i.hit_slot : '0;
      shown_q   <= shown_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_matched_o = matched_q;
  assign out_slot_o    = slot_q;
  assign out_count_o   = shown_q;

endmodule

`default_nettype wire

// ===== hdl/probe_response_matcher_unit.sv =====
// Top level of the probe response matcher: input decode, configuration
// register, chain of table cells and the batch tail. Depends on prm_pkg,
// prm_cell and prm_batch.
//
//   Channel   Direction  Handshake              Contents
//   s_axis    in         tvalid/tready          load or response request
//   m_axis    out        tvalid/tready          match result, one per request
//   APB       in         psel/penable/pwrite    local_address register
//
// Each request walks down a row of ENTRIES cells, one cell per cycle while
// m_axis does not stall. The accepting edge loads the stage register of the
// first cell, each cell register passes it on to the next, and the batch tail
// registers the result after the last cell. The chain is a pipeline: a new
// request enters every cycle unless a waiting result stalls it, and the sustained
// rate is then one request per cycle. The depth of the cell row sets the latency.
// Reset clears the entry kinds and states and every stage valid bit at once;
// no clearing pass is needed. When a result waits on m_axis, the whole chain
// holds and s_axis_tready drops in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module probe_response_matcher_unit
  import prm_pkg::*;
#(
  parameter int ENTRIES = DefaultEntries
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  // Request channel.
  input  wire               s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata from bit 0 up: slot[4], probe_kind[2], remote_ip[32], local_ip[32],
  // protocol[8], icmp_kind[8], first_key[16], second_key[16], two zero bits.
  input  wire  [119:0]      s_axis_tdata,
  // tuser: func.
  input  wire               s_axis_tuser,
  input  wire               s_axis_tlast,
  // Result channel.
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  // tdata from bit 0 up: matched_slot[4], batch_matches[5], seven zero bits.
  output logic [15:0]       m_axis_tdata,
  // tuser: matched.
  output logic              m_axis_tuser,
  // Configuration port.
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [AddrW-1:0]  paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0]       local_addr_q;
  logic              advance;
  req_t              head;
  req_t              chain [0:ENTRIES];
  logic              out_matched;
  logic [SlotW-1:0]  out_slot;
  logic [CountW-1:0] out_count;

  // The register is written at the access phase; reads return its value.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == RegLocalAddress)) begin
      local_addr_q <= pwdata;
    end
  end

  assign prdata = (paddr[2] == RegLocalAddress) ? local_addr_q : '0;

  // The address and protocol checks do not depend on any entry, so they are
  // made once here and travel down the chain as flags.
  always_comb begin
    head          = '0;
    head.valid    = s_axis_tvalid;
    head.func     = s_axis_tuser;
    head.slot     = s_axis_tdata[3:0];
    head.kind     = s_axis_tdata[5:4];
    head.remote   = s_axis_tdata[37:6];
    head.dst_ok   = s_axis_tdata[69:38] == local_addr_q;
    head.tcp_ok   = s_axis_tdata[77:70] == IpprotoTcp;
    head.icmp_ok  = (s_axis_tdata[77:70] == IpprotoIcmp) &&
                    (s_axis_tdata[85:78] == IcmpEchoReply);
    head.first    = s_axis_tdata[101:86];
    head.second   = s_axis_tdata[117:102];
    head.last     = s_axis_tlast;
    head.hit      = 1'b0;
    head.hit_slot = '0;
  end

  assign chain[0]      = head;
  assign s_axis_tready = advance;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    prm_cell #(
      .INDEX(i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .advance_i(advance),
      .req_i    (chain[i]),
      .req_o    (chain[i+1])
    );
  end

  prm_batch u_batch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (chain[ENTRIES]),
    .out_ready_i  (m_axis_tready),
    .advance_o    (advance),
    .out_valid_o  (m_axis_tvalid),
    .out_matched_o(out_matched),
    .out_slot_o   (out_slot),
    .out_count_o  (out_count)
  );

  assign m_axis_tuser = out_matched;
  assign m_axis_tdata = {7'd0, out_count, out_slot};

endmodule

`default_nettype wire

// ===== hdl/prm_checker.sv =====
// Port-level checks for the probe response matcher and the bind that
// attaches them to the top level. Depends on prm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prm_checker
  import prm_pkg::*;
(
  input wire              clk_i,
  input wire              rst_ni,
  input wire              m_axis_tvalid,
  input wire              m_axis_tready,
  input wire [15:0]       m_axis_tdata,
  input wire              m_axis_tuser,
  input wire              psel,
  input wire              penable,
  input wire              pwrite,
  input wire [AddrW-1:0]  paddr,
  input wire [31:0]       pwdata,
  input wire [31:0]       prdata,
  input wire              pready
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A result without a match reports slot zero.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[3:0] == '0)
    else $error("nonzero slot without a match");

  // A match is counted in its own batch, and the count saturates.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[8:4] <= CountMax) &&
      (!m_axis_tuser || (m_axis_tdata[8:4] != '0)))
    else $error("batch count out of range");

  // A write to the address register reads back at once.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[2] == RegLocalAddress) |=>
      (paddr[2] != RegLocalAddress) || (prdata == $past(pwdata)) ||
      (psel && penable && pwrite))
    else $error("local address readback mismatch");

endmodule

bind probe_response_matcher_unit prm_checker u_prm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata),
  .pready       (pready)
);

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for probe_response_matcher_unit: loads and responses
// go in on s_axis, and each match result is checked against a local predictor.
// Depends on prm_pkg and the probe_response_matcher_unit RTL only.
`timescale 1ns / 1ps

module tb;
  import prm_pkg::*;

  localparam int Entries     = DefaultEntries;
  localparam int CycleLimit  = 200_000;
  // The cell row is Entries deep; the drain wait covers that depth with a
  // little margin on top.
  localparam int DrainCycles = Entries + 4;
  localparam int Phases      = 5;

  // Kinds that the package does not name: both are stored, but neither can match.
  localparam logic [1:0] KindOther = 2'd0;
  localparam logic [1:0] KindSpare = 2'd3;

  // local_address is register 0, which sits at byte address 0.
  localparam logic [AddrW-1:0] LocalAddrPaddr = {RegLocalAddress, 2'b00};

  typedef struct {
    logic             func;
    logic [SlotW-1:0] slot;
    logic [1:0]       kind;
    logic [31:0]      remote;
    logic [31:0]      dest;
    logic [7:0]       proto;
    logic [7:0]       icmp_type;
    logic [15:0]      first;
    logic [15:0]      second;
    logic             last;
    int unsigned      idle;   // cycles the sender waits before offering it
  } probe_req_t;

  typedef struct {
    logic              matched;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] count;
  } match_verdict_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [119:0]      s_axis_tdata  = '0;
  logic              s_axis_tuser  = 1'b0;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;
  logic              m_axis_tuser;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [AddrW-1:0]  paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;

  probe_response_matcher_unit #(
    .ENTRIES(Entries)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a copy of the probe table, the batch count and the
  // configured host address. It is updated once per accepted request.
  // ---------------------------------------------------------------------------
  logic [1:0]        tbl_kind   [Entries] = '{default: KindOther};
  status_e           tbl_status [Entries] = '{default: StIdle};
  logic [31:0]       tbl_remote [Entries];
  logic [15:0]       tbl_first  [Entries];
  logic [15:0]       tbl_second [Entries];
  logic [CountW-1:0] batch_tally = '0;
  logic [31:0]       host_addr   = '0;

  probe_req_t     requests_to_send [$];
  match_verdict_t verdicts_due     [$];

  int fault_count    = 0;
  int loads_seen     = 0;
  int responses_seen = 0;
  int hits_seen      = 0;
  int saturated_hits = 0;
  int cycle_count    = 0;

  // Stimulus-side record of what was loaded into each slot, used to build
  // responses that hit. It does not track the answered state on purpose, so
  // repeated responses to an already answered entry also occur.
  bit          gen_loaded [Entries] = '{default: 1'b0};
  logic [1:0]  gen_kind   [Entries];
  logic [31:0] gen_remote [Entries];
  logic [15:0] gen_first  [Entries];
  logic [15:0] gen_second [Entries];
  logic [31:0] plan_host = '0;
  // A few shared target addresses make duplicate entries, so that the
  // lowest-index rule gets exercised in the random part as well.
  logic [31:0] target_pool [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hC0A8_0A14,
                                   32'h0A00_0002};

  bit steady_sender   = 1'b0;
  bit steady_receiver = 1'b0;

  // Works out the result of one accepted request and queues it. A response
  // answers only the lowest pending entry that fits, and the batch count
  // saturates at CountMax and clears after a response that ends a batch.
  function automatic void predict_match(input probe_req_t r);
    match_verdict_t v;
    logic ok;
    v.matched = 1'b0;
    v.slot    = '0;
    if (r.func == FuncLoad) begin
      tbl_kind[r.slot]   = r.kind;
      tbl_status[r.slot] = StPending;
      tbl_remote[r.slot] = r.remote;
      tbl_first[r.slot]  = r.first;
      tbl_second[r.slot] = r.second;
      loads_seen++;
    end else begin
      responses_seen++;
      for (int e = 0; e < Entries && !v.matched; e++) begin
        // TCP ports come back crossed, which is already how the response
        // fields are defined, so both kinds compare first to first.
        ok = tbl_status[e] == StPending && r.remote == tbl_remote[e] &&
             r.dest == host_addr && r.first == tbl_first[e] &&
             r.second == tbl_second[e];
        if (tbl_kind[e] == KindTcp) begin
          ok = ok && r.proto == IpprotoTcp;
        end else if (tbl_kind[e] == KindIcmp) begin
          ok = ok && r.proto == IpprotoIcmp && r.icmp_type == IcmpEchoReply;
        end else begin
          ok = 1'b0;
        end
        if (ok) begin
          tbl_status[e] = StAnswered;
          v.matched     = 1'b1;
          v.slot        = SlotW'(e);
        end
      end
      if (v.matched) begin
        hits_seen++;
        if (batch_tally < CountMax) begin
          batch_tally++;
        end else begin
          saturated_hits++;
        end
      end
    end
    v.count = batch_tally;
    if (r.func == FuncResponse && r.last) begin
      batch_tally = '0;
    end
    verdicts_due.push_back(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. It holds a request on the bus until it is taken, then
  // pulls the next one from the queue and waits out that request's idle
  // count first. The prediction is made at the edge that accepts the request.
  // ---------------------------------------------------------------------------
  probe_req_t  on_bus;
  probe_req_t  next_req;
  bit          staged    = 1'b0;
  int unsigned idle_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      staged         = 1'b0;
      idle_left      = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_match(on_bus);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (!staged && requests_to_send.size() > 0) begin
          next_req  = requests_to_send.pop_front();
          staged    = 1'b1;
          idle_left = next_req.idle;
        end
        if (staged && idle_left == 0) begin
          on_bus = next_req;
          staged = 1'b0;
          s_axis_tdata <= {2'b00, next_req.second, next_req.first, next_req.icmp_type,
                           next_req.proto, next_req.dest, next_req.remote,
                           next_req.kind, next_req.slot};
          s_axis_tuser  <= next_req.func;
          s_axis_tlast  <= next_req.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
          if (staged) begin
            idle_left--;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor. Every accepted result is compared with the oldest
  // prediction. After each result the receiver draws a random stall, except
  // during steady stretches where it stays ready.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    match_verdict_t want;
    int unsigned    wait_n;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left     = 0;
    end else begin
      wait_n = stall_left;
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: result with nothing expected, got matched=%0d slot=%0d count=%0d",
                   $time, m_axis_tuser, m_axis_tdata[SlotW-1:0],
                   m_axis_tdata[SlotW+CountW-1:SlotW]);
          fault_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (m_axis_tuser !== want.matched ||
              m_axis_tdata[SlotW-1:0] !== want.slot ||
              m_axis_tdata[SlotW+CountW-1:SlotW] !== want.count) begin
            $display("%0t: mismatch, expected m=%0d s=%0d c=%0d, got m=%0d s=%0d c=%0d",
                     $time, want.matched, want.slot, want.count, m_axis_tuser,
                     m_axis_tdata[SlotW-1:0], m_axis_tdata[SlotW+CountW-1:SlotW]);
            fault_count++;
          end
        end
        if ($urandom_range(0, 29) == 0) begin
          steady_receiver = !steady_receiver;
        end
        wait_n = steady_receiver ? 0 : $urandom_range(0, 3);
      end
      if (wait_n == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        wait_n--;
      end
      stall_left = wait_n;
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("probe_response_matcher_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic int unsigned draw_sender_gap();
    return steady_sender ? 0 : $urandom_range(0, 3);
  endfunction

  // Fields that a load does not use carry random bits, since the block ignores them.
  task automatic push_load(input logic [SlotW-1:0] slot, input logic [1:0] kind,
                           input logic [31:0] target, input logic [15:0] k1,
                           input logic [15:0] k2, input logic last);
    probe_req_t r;
    r.func      = FuncLoad;
    r.slot      = slot;
    r.kind      = kind;
    r.remote    = target;
    r.dest      = $urandom;
    r.proto     = $urandom;
    r.icmp_type = $urandom;
    r.first     = k1;
    r.second    = k2;
    r.last      = last;
    r.idle      = draw_sender_gap();
    gen_loaded[slot] = 1'b1;
    gen_kind[slot]   = kind;
    gen_remote[slot] = target;
    gen_first[slot]  = k1;
    gen_second[slot] = k2;
    requests_to_send.push_back(r);
  endtask

  task automatic push_response(input logic [31:0] src, input logic [31:0] dst,
                               input logic [7:0] proto, input logic [7:0] itype,
                               input logic [15:0] k1, input logic [15:0] k2,
                               input logic last);
    probe_req_t r;
    r.func      = FuncResponse;
    r.slot      = $urandom;
    r.kind      = $urandom;
    r.remote    = src;
    r.dest      = dst;
    r.proto     = proto;
    r.icmp_type = itype;
    r.first     = k1;
    r.second    = k2;
    r.last      = last;
    r.idle      = draw_sender_gap();
    requests_to_send.push_back(r);
  endtask

  // Directed opening: each kind, each reason a response can miss, the
  // lowest-index rule, overwrite of a used slot, a load that carries the
  // batch end flag, and the extreme values of addresses and keys.
  task automatic queue_directed();
    logic [31:0] h;
    logic [31:0] peer;
    h    = plan_host;
    peer = 32'hC0A8_0A14;
    push_load(4'd0, KindTcp, peer, 16'd80, 16'd40000, 1'b0);
    push_load(4'd15, KindIcmp, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 1'b0);
    push_load(4'd3, KindOther, peer, 16'd80, 16'd40000, 1'b0);
    push_load(4'd7, KindSpare, 32'h0, 16'h0000, 16'h0000, 1'b1);
    // First hit on slot 0; a repeat then finds it answered.
    push_response(peer, h, IpprotoTcp, 8'hFF, 16'd80, 16'd40000, 1'b0);
    push_response(peer, h, IpprotoTcp, 8'hFF, 16'd80, 16'd40000, 1'b0);
    // Echo request instead of echo reply, then the wrong destination.
    push_response(32'hFFFF_FFFF, h, IpprotoIcmp, 8'd8, 16'hFFFF, 16'h0000, 1'b0);
    push_response(32'hFFFF_FFFF, ~h, IpprotoIcmp, IcmpEchoReply, 16'hFFFF, 16'h0000,
                  1'b0);
    // The ICMP hit closes the batch.
    push_response(32'hFFFF_FFFF, h, IpprotoIcmp, IcmpEchoReply, 16'hFFFF, 16'h0000,
                  1'b1);
    // Two identical TCP entries; slot 0 is written again over its answered state.
    push_load(4'd5, KindTcp, peer, 16'd80, 16'd40000, 1'b1);
    push_load(4'd0, KindTcp, peer, 16'd80, 16'd40000, 1'b0);
    push_response(peer, h, IpprotoIcmp, IcmpEchoReply, 16'd80, 16'd40000, 1'b0);
    push_response(peer, h, IpprotoTcp, 8'h00, 16'd40000, 16'd80, 1'b0);
    push_response(peer ^ 32'd1, h, IpprotoTcp, 8'h00, 16'd80, 16'd40000, 1'b0);
    push_response(peer, h, IpprotoTcp, 8'h00, 16'd80, 16'd40000, 1'b0);
    push_response(peer, h, IpprotoTcp, 8'h00, 16'd80, 16'd40000, 1'b0);
    // Fits the spare-kind entry in slot 7 field for field, but that kind never matches.
    push_response(32'h0, h, IpprotoTcp, 8'h00, 16'h0000, 16'h0000, 1'b0);
    push_load(4'd15, KindIcmp, 32'h0, 16'h0000, 16'hFFFF, 1'b0);
    push_response(32'h0, h, IpprotoIcmp, IcmpEchoReply, 16'h0000, 16'hFFFF, 1'b0);
    push_response(32'h0, 32'h0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
  endtask

  // Random phase: mostly loads and responses built to hit a loaded entry,
  // some near misses with one field spoiled, and some pure noise. A batch
  // ends on roughly one response in batch_odds + 1, so long batches can run
  // the count into saturation.
  task automatic queue_random_phase(input int count, input int batch_odds);
    int          pick;
    int          s;
    logic [1:0]  kind;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [7:0]  itype;
    logic [15:0] k1;
    logic [15:0] k2;
    logic [15:0] swap;
    bit          any_loaded;
    any_loaded = 1'b0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 29) == 0) begin
        steady_sender = !steady_sender;
      end
      foreach (gen_loaded[i]) any_loaded |= gen_loaded[i];
      pick = $urandom_range(0, 99);
      s    = $urandom_range(0, Entries - 1);
      if (pick < 35 || !any_loaded) begin
        kind = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                           : 2'($urandom_range(1, 2));
        src  = ($urandom_range(0, 2) == 0) ? target_pool[$urandom_range(0, 3)] : $urandom;
        k1   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        k2   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        push_load(SlotW'(s), kind, src, k1, k2, 1'($urandom));
      end else begin
        while (!gen_loaded[s]) s = (s + 1) % Entries;
        src   = gen_remote[s];
        dst   = plan_host;
        proto = (gen_kind[s] == KindIcmp) ? IpprotoIcmp : IpprotoTcp;
        itype = (gen_kind[s] == KindIcmp) ? IcmpEchoReply : 8'($urandom);
        k1    = gen_first[s];
        k2    = gen_second[s];
        if (pick >= 80 && pick < 92) begin
          case ($urandom_range(0, 5))
            0: src ^= 32'd1 << $urandom_range(0, 31);
            1: dst ^= 32'd1 << $urandom_range(0, 31);
            2: proto = (proto == IpprotoTcp) ? IpprotoIcmp : IpprotoTcp;
            // Only spoils ICMP; a TCP entry ignores the ICMP type.
            3: itype = 8'($urandom_range(1, 255));
            4: begin
              swap = k1;
              k1   = k2;
              k2   = swap;
            end
            default: k2 ^= 16'd1 << $urandom_range(0, 15);
          endcase
        end else if (pick >= 92) begin
          src   = $urandom;
          dst   = $urandom;
          proto = $urandom;
          itype = $urandom;
          k1    = $urandom;
          k2    = $urandom;
        end
        push_response(src, dst, proto, itype, k1, k2, $urandom_range(0, batch_odds) == 0);
      end
    end
  endtask

  // Returns once every request has been taken and every result has come
  // back, then lets the pipeline run empty for a while.
  task automatic wait_until_settled();
    do @(negedge clk_i);
    while (requests_to_send.size() != 0 || staged || s_axis_tvalid ||
           verdicts_due.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // APB write of local_address followed by a read back. Both happen only
  // while the block is idle, so the predictor copy can switch at once.
  task automatic program_local_address(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LocalAddrPaddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    host_addr = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== value) begin
      $display("%0t: local_address read back mismatch, expected %h, got %h",
               $time, value, prdata);
      fault_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Run sequence: reset, then five phases, each with its own host address.
  // The first phase is the directed set; the others are random with
  // different batch lengths. Zero and all ones are among the addresses.
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    logic [31:0] host_plan  [Phases];
    int          batch_odds [Phases];
    host_plan  = '{32'h0A00_0001, 32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
    batch_odds = '{0, 10, 60, 25, 40};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < Phases; p++) begin
      program_local_address(host_plan[p]);
      plan_host = host_plan[p];
      @(negedge clk_i);
      if (p == 0) begin
        queue_directed();
      end else begin
        queue_random_phase(185, batch_odds[p]);
      end
      wait_until_settled();
    end
    $display("Run covered %0d loads and %0d responses over %0d host address settings.",
             loads_seen, responses_seen, Phases);
    $display("%0d responses hit a pending probe, %0d of them at the count ceiling.",
             hits_seen, saturated_hits);
    if (fault_count == 0) begin
      $display("probe_response_matcher_unit verification clean");
    end else begin
      $display("probe_response_matcher_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/prm_pkg.sv
hdl/prm_cell.sv
hdl/prm_batch.sv
hdl/probe_response_matcher_unit.sv
hdl/prm_checker.sv
sim/tb.sv
